>>> hdl/kbd_pkg.sv
// Package with the shared types, codes, scancode constants and key tables of the decoder.
package kbd_pkg;

   // Command queue geometry.
   localparam int CMD_QUEUE_DEPTH = 32;
   localparam int IDX_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   // Output buffer geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_FILL_W = $clog2(RSP_DEPTH + 1);

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] kind_type;
   typedef logic [7:0] byte_type;
   typedef logic [2:0] leds_type;
   typedef logic [IDX_W-1:0] qidx_type;
   typedef logic [CNT_W-1:0] qcnt_type;

   // Request opcodes; the unused code acts as a service tick.
   localparam opcode_type OP_SCAN = 2'd0;
   localparam opcode_type OP_TICK = 2'd1;
   localparam opcode_type OP_LOAD = 2'd2;

   // Result kinds.
   localparam kind_type KIND_CHAR = 2'd0;
   localparam kind_type KIND_SEND = 2'd1;
   localparam kind_type KIND_HOTKEY = 2'd2;

   // Hotkey codes.
   localparam byte_type HK_TAB = 8'd0;
   localparam byte_type HK_BREAK = 8'd1;
   localparam byte_type HK_NEW_CONSOLE = 8'd2;
   localparam byte_type HK_RAISE = 8'd3;

   // Scancodes and keyboard protocol bytes.
   localparam byte_type SC_TAB = 8'h0f;
   localparam byte_type SC_F1 = 8'h3b;
   localparam byte_type SC_F2 = 8'h3c;
   localparam byte_type SC_F11 = 8'h57;
   localparam byte_type SC_LSHIFT_MAKE = 8'h2a;
   localparam byte_type SC_RSHIFT_MAKE = 8'h36;
   localparam byte_type SC_LSHIFT_BREAK = 8'haa;
   localparam byte_type SC_RSHIFT_BREAK = 8'hb6;
   localparam byte_type SC_CAPS_LOCK = 8'h3a;
   localparam byte_type SC_NUM_LOCK = 8'h45;
   localparam byte_type SC_SCROLL_LOCK = 8'h46;
   localparam byte_type ACK_BYTE = 8'hfa;
   localparam byte_type RESEND_BYTE = 8'hfe;
   localparam byte_type LED_CMD = 8'hed;
   localparam byte_type LOWER_CASE_OFFSET = 8'h20;

   // LED bit masks.
   localparam leds_type LED_CAPS = 3'b100;
   localparam leds_type LED_NUM = 3'b010;
   localparam leds_type LED_SCROLL = 3'b001;

   // One result as it sits in the output buffer.
   typedef struct packed {
      kind_type kind;
      byte_type value;
      logic     last;
   } rsp_item_type;

   // Up to two results written into the output buffer in one cycle, packed from slot a.
   typedef struct packed {
      logic         a_valid;
      rsp_item_type a;
      logic         b_valid;
      rsp_item_type b;
   } rsp_push_type;

   // Next queue index with wrap-around at the depth.
   function automatic qidx_type next_idx(qidx_type idx);
      qidx_type result;
      if (32'(idx) + 32'd1 >= 32'(CMD_QUEUE_DEPTH)) begin
         result = '0;
      end else begin
         result = idx + qidx_type'(1);
      end
      return result;
   endfunction

   // Key tables, unshifted and shifted, for scancodes below 0x80.
   function automatic byte_type key_map(logic [6:0] code, logic shifted);
      byte_type ch;
      case (code)
         7'h02: ch = shifted ? 8'h21 : 8'h31;
         7'h03: ch = shifted ? 8'h22 : 8'h32;
         7'h04: ch = shifted ? 8'h23 : 8'h33;
         7'h05: ch = shifted ? 8'h24 : 8'h34;
         7'h06: ch = shifted ? 8'h25 : 8'h35;
         7'h07: ch = shifted ? 8'h26 : 8'h36;
         7'h08: ch = shifted ? 8'h27 : 8'h37;
         7'h09: ch = shifted ? 8'h28 : 8'h38;
         7'h0a: ch = shifted ? 8'h29 : 8'h39;
         7'h0b: ch = shifted ? 8'h7e : 8'h30;
         7'h0c: ch = shifted ? 8'h3d : 8'h2d;
         7'h0d: ch = shifted ? 8'h7e : 8'h5e;
         7'h0e: ch = 8'h08;
         7'h10: ch = 8'h51;
         7'h11: ch = 8'h57;
         7'h12: ch = 8'h45;
         7'h13: ch = 8'h52;
         7'h14: ch = 8'h54;
         7'h15: ch = 8'h59;
         7'h16: ch = 8'h55;
         7'h17: ch = 8'h49;
         7'h18: ch = 8'h4f;
         7'h19: ch = 8'h50;
         7'h1a: ch = shifted ? 8'h60 : 8'h40;
         7'h1b: ch = shifted ? 8'h7b : 8'h5b;
         7'h1c: ch = 8'h0a;
         7'h1e: ch = 8'h41;
         7'h1f: ch = 8'h53;
         7'h20: ch = 8'h44;
         7'h21: ch = 8'h46;
         7'h22: ch = 8'h47;
         7'h23: ch = 8'h48;
         7'h24: ch = 8'h4a;
         7'h25: ch = 8'h4b;
         7'h26: ch = 8'h4c;
         7'h27: ch = shifted ? 8'h2b : 8'h3b;
         7'h28: ch = shifted ? 8'h2a : 8'h3a;
         7'h2b: ch = shifted ? 8'h7d : 8'h5d;
         7'h2c: ch = 8'h5a;
         7'h2d: ch = 8'h58;
         7'h2e: ch = 8'h43;
         7'h2f: ch = 8'h56;
         7'h30: ch = 8'h42;
         7'h31: ch = 8'h4e;
         7'h32: ch = 8'h4d;
         7'h33: ch = shifted ? 8'h3c : 8'h2c;
         7'h34: ch = shifted ? 8'h3e : 8'h2e;
         7'h35: ch = shifted ? 8'h3f : 8'h2f;
         7'h37: ch = 8'h2a;
         7'h39: ch = 8'h20;
         7'h47: ch = 8'h37;
         7'h48: ch = 8'h38;
         7'h49: ch = 8'h39;
         7'h4a: ch = 8'h2d;
         7'h4b: ch = 8'h34;
         7'h4c: ch = 8'h35;
         7'h4d: ch = 8'h36;
         7'h4e: ch = 8'h2b;
         7'h4f: ch = 8'h31;
         7'h50: ch = 8'h32;
         7'h51: ch = 8'h33;
         7'h52: ch = 8'h30;
         7'h53: ch = 8'h2e;
         7'h73: ch = shifted ? 8'h5f : 8'h5c;
         7'h7d: ch = shifted ? 8'h7c : 8'h5c;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/kbd_req_if.sv
// Interface of the request channel: one scancode or command transaction.
interface kbd_req_if;
   logic                valid;
   logic                ready;
   kbd_pkg::opcode_type opcode;
   kbd_pkg::byte_type   scancode;

   modport source (output valid, output opcode, output scancode, input ready);
   modport sink (input valid, input opcode, input scancode, output ready);
endinterface

>>> hdl/kbd_rsp_if.sv
// Interface of the response channel: one character, command byte or hotkey transaction.
interface kbd_rsp_if;
   logic              valid;
   logic              ready;
   kbd_pkg::kind_type kind;
   kbd_pkg::byte_type value;
   logic              last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

>>> hdl/keyboard_scancode_decoder.sv
// Top level of the keyboard scancode decoder with its command queue memory.
//
// Use: scancodes and commands enter on req_bus (opcode, scancode). Results leave on rsp_bus
// as kind/value/last transactions: a character or hotkey first, then at most one byte to
// send to the keyboard; last marks the final result of a request, and a request may give
// none. csr_we/csr_wdata load the initial LED value that the load opcode applies.
// Timing: a request is evaluated in the cycle after it is taken; in the cycle after that
// its results enter a four-entry output buffer. No new request is taken in the evaluation
// step, but the next one may be taken in the send step of the last. This is set by the
// single write port of the command queue memory, which stores the two bytes of an LED
// command pair in the evaluation step and in the send step.
// Reset: shift, lock and acknowledge state and the queue pointers clear at once; the queue
// memory itself is not cleared, and only written entries are ever read.
// Stalls: while rsp_bus is stalled, requests keep being accepted as long as the output
// buffer has room for two more results; after that req_bus.ready stays low.
module keyboard_scancode_decoder (
   input  logic              clock,
   input  logic              reset,
   kbd_req_if.sink           req_bus,
   kbd_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  kbd_pkg::leds_type csr_wdata
);
   import kbd_pkg::*;

   // Request sequencing states.
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_EVAL = 3'b010,
      PH_SEND = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in;

   // Configuration and persistent state.
   leds_type  initial_leds_ff;
   logic [1:0] shift_bits_ff, shift_bits_in;
   leds_type  lock_leds_ff, lock_leds_in;
   logic      out_valid_ff, out_valid_in;
   byte_type  out_byte_ff, out_byte_in;
   qidx_type  head_ff, head_in;
   qidx_type  tail_ff, tail_in;
   qcnt_type  count_ff, count_in;

   // Command queue memory.
   byte_type  queue_mem [CMD_QUEUE_DEPTH];
   byte_type  rdata_ff;
   logic      mem_we;
   qidx_type  mem_waddr;
   byte_type  mem_wdata;

   // Accepted request.
   opcode_type op_ff;
   byte_type   sc_ff;

   // Results of the evaluation step, held for the send step.
   logic      r1_valid_ff, r1_valid_in;
   kind_type  r1_kind_ff, r1_kind_in;
   byte_type  r1_value_ff, r1_value_in;
   logic      resend_ff, resend_in;
   logic      pop_ff, pop_in;
   logic      pop_fwd_ff, pop_fwd_in;
   logic      push2_ff, push2_in;
   qidx_type  push2_addr_ff, push2_addr_in;
   byte_type  push2_data_ff, push2_data_in;

   // Evaluation step signals.
   logic      req_take;
   logic      shifted;
   byte_type  map_ch;
   byte_type  ch;
   logic      is_scan;
   logic      push_req;
   logic      ack;
   logic      out_mid;
   logic      push1;
   qcnt_type  after1;
   qcnt_type  after2;
   qidx_type  tail1;

   // Send step and output buffer signals.
   byte_type              send_value;
   logic                  send_valid;
   rsp_push_type          push;
   logic [RSP_FILL_W-1:0] fill;
   logic [RSP_FILL_W-1:0] pending;

   // Accept when the output buffer can take two more results after the ones in flight.
   assign send_valid = resend_ff | pop_ff;
   assign pending = (phase_ff == PH_SEND)
      ? (RSP_FILL_W'(r1_valid_ff) + RSP_FILL_W'(send_valid)) : '0;
   assign req_bus.ready = ((phase_ff == PH_IDLE) || (phase_ff == PH_SEND))
      && ((fill + pending) <= RSP_FILL_W'(RSP_DEPTH - 2));
   assign req_take = req_bus.valid & req_bus.ready;

   // Sequencer.
   always_comb begin
      unique case (phase_ff)
         PH_IDLE: phase_in = req_take ? PH_EVAL : PH_IDLE;
         PH_EVAL: phase_in = PH_SEND;
         PH_SEND: phase_in = req_take ? PH_EVAL : PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Character lookup and the first result.
   always_comb begin
      is_scan = (op_ff == OP_SCAN);
      shifted = |shift_bits_ff;
      map_ch = sc_ff[7] ? 8'h00 : key_map(sc_ff[6:0], shifted);
      ch = map_ch;
      if ((map_ch >= 8'h41) && (map_ch <= 8'h5a) && ((lock_leds_ff[2]) == shifted)) begin
         ch = map_ch + LOWER_CASE_OFFSET;
      end
      r1_valid_in = 1'b0;
      r1_kind_in = KIND_CHAR;
      r1_value_in = ch;
      if (is_scan) begin
         if (ch != 8'h00) begin
            r1_valid_in = 1'b1;
         end else if (sc_ff == SC_TAB) begin
            r1_valid_in = 1'b1;
            r1_kind_in = KIND_HOTKEY;
            r1_value_in = HK_TAB;
         end else if ((sc_ff == SC_F1) && shifted) begin
            r1_valid_in = 1'b1;
            r1_kind_in = KIND_HOTKEY;
            r1_value_in = HK_BREAK;
         end else if ((sc_ff == SC_F2) && shifted) begin
            r1_valid_in = 1'b1;
            r1_kind_in = KIND_HOTKEY;
            r1_value_in = HK_NEW_CONSOLE;
         end else if (sc_ff == SC_F11) begin
            r1_valid_in = 1'b1;
            r1_kind_in = KIND_HOTKEY;
            r1_value_in = HK_RAISE;
         end
      end
   end

   // Shift, lock, acknowledge and queue updates of the evaluation step.
   always_comb begin
      shift_bits_in = shift_bits_ff;
      lock_leds_in = lock_leds_ff;
      push_req = 1'b0;
      ack = 1'b0;
      resend_in = 1'b0;
      if (is_scan) begin
         if (sc_ff == SC_LSHIFT_MAKE) shift_bits_in[0] = 1'b1;
         if (sc_ff == SC_RSHIFT_MAKE) shift_bits_in[1] = 1'b1;
         if (sc_ff == SC_LSHIFT_BREAK) shift_bits_in[0] = 1'b0;
         if (sc_ff == SC_RSHIFT_BREAK) shift_bits_in[1] = 1'b0;
         if (sc_ff == SC_CAPS_LOCK) begin
            lock_leds_in = lock_leds_ff ^ LED_CAPS;
            push_req = 1'b1;
         end
         if (sc_ff == SC_NUM_LOCK) begin
            lock_leds_in = lock_leds_ff ^ LED_NUM;
            push_req = 1'b1;
         end
         if (sc_ff == SC_SCROLL_LOCK) begin
            lock_leds_in = lock_leds_ff ^ LED_SCROLL;
            push_req = 1'b1;
         end
         ack = (sc_ff == ACK_BYTE);
         resend_in = (sc_ff == RESEND_BYTE) && out_valid_ff;
      end else if (op_ff == OP_LOAD) begin
         lock_leds_in = initial_leds_ff;
         push_req = 1'b1;
      end

      // Each byte of the pair is dropped on its own when the queue is full.
      push1 = push_req && (count_ff < CNT_W'(CMD_QUEUE_DEPTH));
      after1 = count_ff + CNT_W'(push1);
      push2_in = push_req && (after1 < CNT_W'(CMD_QUEUE_DEPTH));
      after2 = after1 + CNT_W'(push2_in);
      tail1 = next_idx(tail_ff);
      push2_addr_in = tail1;
      push2_data_in = byte_type'(lock_leds_in);

      // Send the next queued byte once nothing waits for an acknowledge.
      out_mid = out_valid_ff & ~ack;
      pop_in = !resend_in && !out_mid && (after2 != '0);
      pop_fwd_in = (count_ff == '0);
      out_valid_in = pop_in | out_mid;
      count_in = after2 - CNT_W'(pop_in);
      head_in = pop_in ? next_idx(head_ff) : head_ff;
      if (push2_in) begin
         tail_in = next_idx(tail1);
      end else if (push1) begin
         tail_in = tail1;
      end else begin
         tail_in = tail_ff;
      end
   end

   // A byte popped from an empty queue is the LED command pushed by this request.
   assign send_value = resend_ff ? out_byte_ff : (pop_fwd_ff ? LED_CMD : rdata_ff);
   assign out_byte_in = send_value;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         initial_leds_ff <= '0;
         shift_bits_ff <= '0;
         lock_leds_ff <= '0;
         out_valid_ff <= 1'b0;
         out_byte_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         r1_valid_ff <= 1'b0;
         resend_ff <= 1'b0;
         pop_ff <= 1'b0;
         push2_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (csr_we) begin
            initial_leds_ff <= csr_wdata;
         end
         if (phase_ff == PH_EVAL) begin
            shift_bits_ff <= shift_bits_in;
            lock_leds_ff <= lock_leds_in;
            out_valid_ff <= out_valid_in;
            head_ff <= head_in;
            tail_ff <= tail_in;
            count_ff <= count_in;
            r1_valid_ff <= r1_valid_in;
            resend_ff <= resend_in;
            pop_ff <= pop_in;
            push2_ff <= push2_in;
         end else begin
            r1_valid_ff <= 1'b0;
            resend_ff <= 1'b0;
            pop_ff <= 1'b0;
            push2_ff <= 1'b0;
         end
         if ((phase_ff == PH_SEND) && pop_ff) begin
            out_byte_ff <= out_byte_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_bus.opcode;
         sc_ff <= req_bus.scancode;
      end
      if (phase_ff == PH_EVAL) begin
         r1_kind_ff <= r1_kind_in;
         r1_value_ff <= r1_value_in;
         pop_fwd_ff <= pop_fwd_in;
         push2_addr_ff <= push2_addr_in;
         push2_data_ff <= push2_data_in;
      end
   end

   // Queue memory: the LED command in the evaluation step, the LED value in the send step.
   always_comb begin
      if (phase_ff == PH_EVAL) begin
         mem_we = push1;
         mem_waddr = tail_ff;
         mem_wdata = LED_CMD;
      end else begin
         mem_we = (phase_ff == PH_SEND) && push2_ff;
         mem_waddr = push2_addr_ff;
         mem_wdata = push2_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= queue_mem[head_ff];
   end

   // Results of the send step, packed from slot a.
   always_comb begin
      push.a_valid = (phase_ff == PH_SEND) && (r1_valid_ff || send_valid);
      push.b_valid = (phase_ff == PH_SEND) && r1_valid_ff && send_valid;
      if (r1_valid_ff) begin
         push.a.kind = r1_kind_ff;
         push.a.value = r1_value_ff;
         push.a.last = !send_valid;
      end else begin
         push.a.kind = KIND_SEND;
         push.a.value = send_value;
         push.a.last = 1'b1;
      end
      push.b.kind = KIND_SEND;
      push.b.value = send_value;
      push.b.last = 1'b1;
   end

   kbd_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .fill    (fill),
      .rsp_bus (rsp_bus)
   );

   // The queue count never exceeds the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CMD_QUEUE_DEPTH))
      else $error("command queue count out of range");

   // Head meets tail only when the queue is empty or full.
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == ((count_ff == '0) || (count_ff == CNT_W'(CMD_QUEUE_DEPTH))))
      else $error("command queue pointers disagree with count");

   // Evaluation is always followed by the send step.
   a_eval_send: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EVAL) |=> (phase_ff == PH_SEND))
      else $error("send step skipped");

   // A byte taken from the queue leaves an acknowledge outstanding.
   a_pop_outstanding: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_EVAL) && pop_in) |=> (out_valid_ff && pop_ff))
      else $error("queued byte sent without outstanding mark");

endmodule

>>> hdl/kbd_rsp_fifo.sv
// Four-entry output buffer that takes up to two results a cycle and drives the response channel.
module kbd_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  kbd_pkg::rsp_push_type               push,
   output logic [kbd_pkg::RSP_FILL_W-1:0]      fill,
   kbd_rsp_if.source                           rsp_bus
);
   import kbd_pkg::*;

   rsp_item_type              slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [RSP_FILL_W-1:0]     fill_ff, fill_in;
   logic                      pop;
   logic [RSP_FILL_W-1:0]     push_n;
   rsp_item_type              head_item;

   assign pop = rsp_bus.valid & rsp_bus.ready;
   assign push_n = RSP_FILL_W'(push.a_valid) + RSP_FILL_W'(push.b_valid);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      fill_in = fill_ff + push_n - RSP_FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // Result storage; slot b follows slot a.
   always_ff @(posedge clock) begin
      if (push.a_valid) begin
         slot_ff[wr_ptr_ff] <= push.a;
      end
      if (push.b_valid) begin
         slot_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.b;
      end
   end

   // Channel outputs.
   assign head_item = slot_ff[rd_ptr_ff];
   assign rsp_bus.valid = (fill_ff != '0);
   assign rsp_bus.kind = head_item.kind;
   assign rsp_bus.value = head_item.value;
   assign rsp_bus.last = head_item.last;
   assign fill = fill_ff;

   // The buffer never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= RSP_FILL_W'(RSP_DEPTH))
      else $error("response buffer overfilled");

   // Slot b is only written together with slot a.
   a_push_packed: assert property (@(posedge clock) disable iff (reset)
      push.b_valid |-> push.a_valid)
      else $error("response push not packed from slot a");

   // Pointers are equal whenever the buffer is empty.
   a_ptr_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("response pointers disagree with fill count");

endmodule
